### sv/dirp_pkg.sv
package dirp_pkg;

	localparam logic [31:0] TYPE_MASK   = 32'hF000_0000;
	localparam logic [31:0] TYPE_DATA   = 32'h4000_0000;
	localparam logic [31:0] TYPE_ZERO   = 32'h8000_0000;
	localparam logic [27:0] COUNT_MAX   = 28'hFFF_FFFF;
	localparam logic [31:0] PROG_HEADER = 32'h0000_0000;

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_ADDRESS = 2'd1;
	localparam logic [1:0] PH_DATA    = 2'd2;
	localparam logic [1:0] PH_PROGRAM = 2'd3;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_FILL    = 2'd1;
	localparam logic [1:0] KIND_PROGRAM = 2'd2;

	typedef struct packed {
		logic [31:0] image_word;
		logic        image_start;
	} image_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [31:0] block_address;
		logic [27:0] word_offset;
		logic [31:0] write_data;
		logic [27:0] fill_length;
	} record_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic        pending_fill;
		logic [27:0] remaining;
		logic [31:0] block_address;
		logic [27:0] offset;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_HEADER, pending_fill: 1'b0, remaining: 28'd0,
		block_address: 32'd0, offset: 28'd0
	};

endpackage

### sv/dirp_stream_if.sv
interface dirp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/dsp_image_record_parser.sv
// Channel | Role   | Payload                                                  | Handshake
// image   | sink   | image_word[32], image_start[1]                           | valid/ready
// record  | source | record_kind[2], block_address[32], word_offset[28],     | valid/ready
//         |        | write_data[32], fill_length[28]                          |
//
// One word is accepted per cycle while the result register is empty or its record is taken;
// its record, if any, is shown on the next cycle from the result register.
// The parser state and the result register are updated in the cycle of acceptance.
// arst_n clears the parser to the header phase and empties the result register.
// A stalled record holds image words back only while the result register is full.
module dsp_image_record_parser
	import dirp_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	dirp_stream_if.sink    image,
	dirp_stream_if.source  record
);

	parse_state_t state_q;
	parse_state_t state_next;
	logic         emit;
	record_t      result;
	record_t      record_q;
	logic         record_valid_q;
	logic         accept;

	assign image.ready = !record_valid_q || record.ready;
	assign accept = image.valid && image.ready;
	assign record.valid = record_valid_q;
	assign record.payload = record_q;

	dirp_step u_step (
		.state      (state_q),
		.image      (image.payload),
		.state_next (state_next),
		.emit       (emit),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			record_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_next;
				record_valid_q <= emit;
			end else if (record.ready) begin
				record_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			record_q <= result;
		end
	end

	a_data_has_words: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DATA |-> state_q.remaining != 28'd0)
		else $error("data phase with no words remaining");

	a_program_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_PROGRAM |-> state_q.block_address == 32'd0)
		else $error("program phase with non-zero block address");

	a_program_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !image.payload.image_start && state_q.phase == PH_PROGRAM)
		|=> record_valid_q && record_q.record_kind == KIND_PROGRAM)
		else $error("program word gave no program record");

	a_fill_returns_header: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && result.record_kind == KIND_FILL)
		|=> state_q.phase == PH_HEADER)
		else $error("zero-fill did not return to header phase");

endmodule

### sv/dirp_step.sv
module dirp_step
	import dirp_pkg::*;
(
	input  parse_state_t state,
	input  image_t       image,
	output parse_state_t state_next,
	output logic         emit,
	output record_t      result
);

	parse_state_t st;
	logic [27:0]  rem_dec;

	always_comb begin
		// A start request returns the parser to reset before this word is parsed.
		st = image.image_start ? STATE_RESET : state;
		rem_dec = st.remaining - 28'd1;
		state_next = st;
		emit = 1'b0;
		result = '{
			record_kind: KIND_DATA, block_address: 32'd0, word_offset: 28'd0,
			write_data: 32'd0, fill_length: 28'd0
		};
		case (st.phase)
			PH_HEADER: begin
				if ((image.image_word & TYPE_MASK) == TYPE_DATA) begin
					state_next.remaining = image.image_word[27:0];
					state_next.pending_fill = 1'b0;
					state_next.phase = PH_ADDRESS;
				end else if ((image.image_word & TYPE_MASK) == TYPE_ZERO) begin
					state_next.remaining = image.image_word[27:0];
					state_next.pending_fill = 1'b1;
					state_next.phase = PH_ADDRESS;
				end else if (image.image_word == PROG_HEADER) begin
					state_next.block_address = 32'd0;
					state_next.offset = 28'd0;
					state_next.phase = PH_PROGRAM;
				end
			end
			PH_ADDRESS: begin
				state_next.block_address = image.image_word;
				state_next.offset = 28'd0;
				if (st.pending_fill) begin
					emit = 1'b1;
					result.record_kind = KIND_FILL;
					result.block_address = image.image_word;
					result.fill_length = st.remaining;
					state_next.remaining = 28'd0;
					state_next.phase = PH_HEADER;
				end else if (st.remaining == 28'd0) begin
					// An empty data block ends with its address word.
					state_next.phase = PH_HEADER;
				end else begin
					state_next.phase = PH_DATA;
				end
			end
			PH_DATA: begin
				emit = 1'b1;
				result.record_kind = KIND_DATA;
				result.block_address = st.block_address;
				result.word_offset = st.offset;
				result.write_data = image.image_word;
				state_next.offset = st.offset + 28'd1;
				state_next.remaining = rem_dec;
				if (rem_dec == 28'd0) begin
					state_next.phase = PH_HEADER;
				end
			end
			default: begin
				emit = 1'b1;
				result.record_kind = KIND_PROGRAM;
				result.word_offset = st.offset;
				result.write_data = image.image_word;
				// The program offset sticks at its maximum.
				if (st.offset != COUNT_MAX) begin
					state_next.offset = st.offset + 28'd1;
				end
			end
		endcase
	end

endmodule
